FILE: rtl/core/lbs_pkg.sv
// ----------------------------------------------------------------------------
// lbs_pkg: shared types and constants for the vertex skinning block
// Request and response item types, sequencer states and the
// controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package lbs_pkg;

   localparam int MAX_BONES_DEF = 64;
   localparam int FRAC_BITS_DEF = 16;
   localparam int WORD_BITS_DEF = 32;
   localparam int ACC_BITS      = 48;
   localparam int WEIGHT_FRAC   = 16;
   localparam int MAT_ELEMS     = 16;
   localparam int BONE_BITS     = 6;
   localparam int ELEM_BITS     = 4;
   localparam int WEIGHT_BITS   = 17;
   localparam int POS_BITS      = 32;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_CONTRIB = 1'b1;
   localparam logic SEL_POSE   = 1'b0;
   localparam logic SEL_BIND   = 1'b1;

   typedef struct packed {
      logic                          opcode;
      logic                          matrix_select;
      logic [BONE_BITS-1:0]          bone_index;
      logic [ELEM_BITS-1:0]          element_index;
      logic signed [POS_BITS-1:0]    element_value;
      logic signed [POS_BITS-1:0]    pos_x;
      logic signed [POS_BITS-1:0]    pos_y;
      logic signed [POS_BITS-1:0]    pos_z;
      logic [WEIGHT_BITS-1:0]        bone_weight;
      logic                          last_bone;
   } req_item_type;

   typedef struct packed {
      logic signed [POS_BITS-1:0] out_x;
      logic signed [POS_BITS-1:0] out_y;
      logic signed [POS_BITS-1:0] out_z;
      logic                       divide_fault;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAT1,
      ST_MAT2,
      ST_CHECK,
      ST_DIV,
      ST_ACC,
      ST_EMIT,
      ST_WAIT
   } lbs_state_type;

   // Command from controller to datapath.
   typedef struct packed {
      logic capture;     // latch the accepted request
      logic write_mem;   // store a matrix element
      logic mat_start;   // begin a matrix pass (reads element 0)
      logic mat_step;    // one multiply-accumulate step
      logic mat_second;  // pass uses pose matrix and first result
      logic div_start;
      logic div_step;
      logic acc_step;
      logic set_fault;
      logic emit;        // load the output register and clear sums
   } lbs_cmd_type;

   typedef struct packed {
      logic mat_done;
      logic div_done;
      logic acc_done;
      logic w_zero;
      logic bone_ok;
      logic is_load;
      logic is_last;
   } lbs_status_type;

endpackage

FILE: rtl/core/lbs_ram.sv
// ----------------------------------------------------------------------------
// lbs_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module lbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

FILE: rtl/core/lbs_ctrl.sv
// ----------------------------------------------------------------------------
// lbs_ctrl: sequencer for the skinning datapath
// Walks each load through its write, each contribution through two matrix passes,
// divide and accumulate (skipped for a zero w); holds the response until taken.
// ----------------------------------------------------------------------------
module lbs_ctrl
   import lbs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  lbs_status_type status,
   output lbs_cmd_type    cmd
);
   lbs_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_free;

   // The output register can take a new item when it is empty or being drained.
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_WAIT;
         ST_WAIT: begin
            if (status.is_load) state_in = ST_IDLE;
            else if (!status.bone_ok) state_in = status.is_last ? ST_EMIT : ST_IDLE;
            else state_in = ST_MAT1;
         end
         ST_MAT1:  if (status.mat_done) state_in = ST_MAT2;
         ST_MAT2:  if (status.mat_done) state_in = ST_CHECK;
         ST_CHECK: begin
            if (status.w_zero) state_in = status.is_last ? ST_EMIT : ST_IDLE;
            else state_in = ST_DIV;
         end
         ST_DIV:   if (status.div_done) state_in = ST_ACC;
         ST_ACC:   if (status.acc_done) state_in = status.is_last ? ST_EMIT : ST_IDLE;
         ST_EMIT:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:  cmd.capture = req_valid;
         ST_WAIT: begin
            cmd.write_mem = status.is_load && status.bone_ok;
            cmd.mat_start = !status.is_load && status.bone_ok;
         end
         ST_MAT1: begin
            cmd.mat_step  = 1'b1;
            cmd.mat_start = status.mat_done;
            cmd.mat_second = status.mat_done;
         end
         ST_MAT2: begin
            cmd.mat_step   = 1'b1;
            cmd.mat_second = 1'b1;
         end
         ST_CHECK: begin
            cmd.set_fault = status.w_zero;
            cmd.div_start = !status.w_zero;
         end
         ST_DIV:   cmd.div_step = 1'b1;
         ST_ACC:   cmd.acc_step = 1'b1;
         ST_EMIT:  cmd.emit = rsp_free;
         default:  cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.emit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule

FILE: rtl/core/lbs_datapath.sv
// ----------------------------------------------------------------------------
// lbs_datapath: matrix stores, shared multiplier, divider and accumulators
// One matrix element is multiplied per cycle; a restoring divider makes
// one quotient bit per cycle; the accumulators take one axis per cycle.
// ----------------------------------------------------------------------------
module lbs_datapath
   import lbs_pkg::*;
#(
   parameter int MAX_BONES = MAX_BONES_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  req_item_type   req_item,
   input  lbs_cmd_type    cmd,
   output lbs_status_type status,
   output rsp_item_type   rsp_item
);
   localparam int WORD_BITS = WORD_BITS_DEF;
   localparam int DEPTH  = MAX_BONES * MAT_ELEMS;
   localparam int ABITS  = $clog2(DEPTH);
   localparam int PBITS  = 2 * WORD_BITS + 2;
   localparam int QBITS  = WORD_BITS + FRAC_BITS + 1;
   localparam int CBITS  = $clog2(QBITS + 1);
   localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic signed [ACC_BITS-1:0]  AMAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0]  AMIN = {1'b1, {(ACC_BITS-1){1'b0}}};
   localparam logic signed [WORD_BITS-1:0] ONE_W =
      (FRAC_BITS >= WORD_BITS - 1) ? WMAX : WORD_BITS'(64'sd1 <<< FRAC_BITS);

   req_item_type req_ff;
   logic signed [WORD_BITS-1:0] vec_ff [4];
   logic signed [WORD_BITS-1:0] res_ff [4];
   logic signed [WORD_BITS+3:0] sum_ff;
   logic [4:0]  step_ff;          // bit 4: data valid delay, [3:0] element
   logic        rd_valid_ff;
   logic [ELEM_BITS-1:0] rd_el_ff;
   logic        second_ff;
   logic signed [ACC_BITS-1:0] acc_ff [3];
   logic        fault_ff;
   rsp_item_type rsp_ff;

   // Stores.
   logic [ELEM_BITS-1:0] rd_el;
   logic [ABITS-1:0]     addr;
   logic [WORD_BITS-1:0] pose_q, bind_q;
   logic                 in_range;
   assign in_range = ({3'b0, req_ff.bone_index} < 9'(MAX_BONES));
   logic [ELEM_BITS-1:0] next_el;
   assign next_el = cmd.mat_start ? '0 : step_ff[3:0] + 4'd1;
   assign rd_el = cmd.write_mem ? req_ff.element_index : next_el;
   assign addr  = ABITS'({req_ff.bone_index, rd_el});

   lbs_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_pose (
      .clock(clock), .wr_en(cmd.write_mem && req_ff.matrix_select == SEL_POSE),
      .addr(addr), .wr_data(req_ff.element_value[WORD_BITS-1:0]), .rd_data(pose_q));
   lbs_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_bind (
      .clock(clock), .wr_en(cmd.write_mem && req_ff.matrix_select == SEL_BIND),
      .addr(addr), .wr_data(req_ff.element_value[WORD_BITS-1:0]), .rd_data(bind_q));

   // Multiply one element by one vector entry, round, saturate.
   logic signed [WORD_BITS-1:0] m_a, m_b;
   logic [WORD_BITS:0] ma_mag, mb_mag;
   logic [PBITS-1:0]   prod, prod_r;
   logic               neg;
   logic [WORD_BITS:0] lim;
   logic signed [WORD_BITS:0] mq;
   logic [PBITS-1:0]   shr;
   assign m_a = second_ff ? pose_q : bind_q;
   assign m_b = vec_ff[rd_el_ff[1:0]];
   assign neg = m_a[WORD_BITS-1] ^ m_b[WORD_BITS-1];
   assign ma_mag = m_a[WORD_BITS-1] ? (WORD_BITS+1)'(-{m_a[WORD_BITS-1], m_a})
                                    : {1'b0, m_a};
   assign mb_mag = m_b[WORD_BITS-1] ? (WORD_BITS+1)'(-{m_b[WORD_BITS-1], m_b})
                                    : {1'b0, m_b};
   assign prod   = PBITS'(ma_mag * mb_mag);
   assign prod_r = prod + (PBITS'(1) << (FRAC_BITS - 1));
   assign shr    = prod_r >> FRAC_BITS;
   assign lim    = neg ? (WORD_BITS+1)'(1) << (WORD_BITS-1)
                       : ((WORD_BITS+1)'(1) << (WORD_BITS-1)) - 1'b1;
   always_comb begin
      logic [WORD_BITS:0] m;
      m = (shr > PBITS'(lim)) ? lim : shr[WORD_BITS:0];
      mq = neg ? -$signed(m) : $signed(m);
   end

   logic signed [WORD_BITS+3:0] sum_next, sum_row;
   logic signed [WORD_BITS-1:0] row_sat;
   assign sum_row = (rd_el_ff[1:0] == 2'd0 ? '0 : sum_ff) + (WORD_BITS+4)'(mq);
   assign row_sat = (sum_row > (WORD_BITS+4)'(WMAX)) ? WMAX :
                    (sum_row < (WORD_BITS+4)'(WMIN)) ? WMIN : sum_row[WORD_BITS-1:0];
   assign sum_next = sum_row;

   logic mat_done;
   assign mat_done = rd_valid_ff && rd_el_ff == 4'd15;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_item;
         vec_ff[0] <= req_item.pos_x[WORD_BITS-1:0];
         vec_ff[1] <= req_item.pos_y[WORD_BITS-1:0];
         vec_ff[2] <= req_item.pos_z[WORD_BITS-1:0];
         vec_ff[3] <= ONE_W;
      end
      if (cmd.mat_start || (cmd.mat_step && !step_ff[4] && step_ff[3:0] != 4'd15)) begin
         step_ff  <= {1'b0, next_el};
         rd_el_ff <= rd_el;
      end else if (cmd.mat_step) begin
         step_ff[4] <= 1'b1;
      end
      second_ff <= cmd.mat_second && !(cmd.mat_start && !cmd.mat_step) ? 1'b1 :
                   (cmd.mat_start && cmd.mat_second) ? 1'b1 :
                   cmd.mat_start ? 1'b0 : second_ff;
      if (rd_valid_ff) begin
         sum_ff <= sum_next;
         if (rd_el_ff[1:0] == 2'd3) res_ff[rd_el_ff[3:2]] <= row_sat;
      end
      if (mat_done && !second_ff) begin
         vec_ff[0] <= res_ff[0];
         vec_ff[1] <= res_ff[1];
         vec_ff[2] <= res_ff[2];
         vec_ff[3] <= row_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rd_valid_ff <= 1'b0;
      else rd_valid_ff <= cmd.mat_start ||
                          (cmd.mat_step && rd_valid_ff && rd_el_ff != 4'd15);
   end

   // Restoring divider, one axis at a time: |r|<<FRAC / |w|, taken from
   // the result of the second (pose) pass.
   logic [1:0]           axis_ff;
   logic [CBITS-1:0]     dcnt_ff;
   logic [QBITS-1:0]     num_ff, quo_ff;
   logic [WORD_BITS:0]   den_ff, rem_ff;
   logic                 dneg_ff, ddone_ff;
   logic signed [WORD_BITS-1:0] qv_ff [3];
   logic signed [WORD_BITS-1:0] wv;
   assign wv = res_ff[3];
   logic [WORD_BITS+1:0] trial;
   assign trial = {rem_ff, num_ff[QBITS-1]};
   logic [WORD_BITS:0] qlim;
   assign qlim = dneg_ff ? (WORD_BITS+1)'(1) << (WORD_BITS-1)
                         : ((WORD_BITS+1)'(1) << (WORD_BITS-1)) - 1'b1;
   logic [WORD_BITS:0]          qmag;
   logic signed [WORD_BITS-1:0] qval;
   assign qmag = (quo_ff > QBITS'(qlim)) ? qlim : quo_ff[WORD_BITS:0];
   assign qval = dneg_ff ? WORD_BITS'(-$signed(qmag)) : qmag[WORD_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.div_start || (cmd.div_step && ddone_ff && axis_ff != 2'd2)) begin
         logic [1:0] ax;
         logic signed [WORD_BITS-1:0] n;
         ax = cmd.div_start ? 2'd0 : axis_ff + 2'd1;
         n  = res_ff[ax];
         if (!cmd.div_start) qv_ff[axis_ff] <= qval;
         axis_ff <= ax;
         num_ff  <= QBITS'(n[WORD_BITS-1] ? (WORD_BITS+1)'(-{n[WORD_BITS-1], n})
                                           : {1'b0, n}) << FRAC_BITS;
         den_ff  <= wv[WORD_BITS-1] ? (WORD_BITS+1)'(-{wv[WORD_BITS-1], wv})
                                     : {1'b0, wv};
         dneg_ff <= n[WORD_BITS-1] ^ wv[WORD_BITS-1];
         rem_ff  <= '0;
         quo_ff  <= '0;
         dcnt_ff <= CBITS'(QBITS);
         ddone_ff <= 1'b0;
      end else if (cmd.div_step && !ddone_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_ff <= (WORD_BITS+1)'(trial - {1'b0, den_ff});
            quo_ff <= {quo_ff[QBITS-2:0], 1'b1};
         end else begin
            rem_ff <= trial[WORD_BITS:0];
            quo_ff <= {quo_ff[QBITS-2:0], 1'b0};
         end
         num_ff  <= num_ff << 1;
         dcnt_ff <= dcnt_ff - 1'b1;
         if (dcnt_ff == CBITS'(1)) ddone_ff <= 1'b1;
      end else if (cmd.div_step && ddone_ff) begin
         qv_ff[axis_ff] <= qval;
      end
   end
   // The done cycle of the last axis stores its quotient and reloads nothing.
   logic div_done;
   assign div_done = cmd.div_step && ddone_ff && axis_ff == 2'd2;

   // Weighted accumulation, one axis a cycle.
   logic [1:0] acc_ax_ff;
   logic signed [WORD_BITS-1:0] av;
   logic [WORD_BITS+WEIGHT_BITS-1:0] wm, wmr;
   logic signed [ACC_BITS+1:0] asum;
   logic [WORD_BITS:0] av_mag;
   assign av     = qv_ff[acc_ax_ff];
   assign av_mag = av[WORD_BITS-1] ? (WORD_BITS+1)'(-{av[WORD_BITS-1], av}) : {1'b0, av};
   assign wm     = (WORD_BITS+WEIGHT_BITS)'(av_mag * req_ff.bone_weight);
   assign wmr    = (wm + (WORD_BITS+WEIGHT_BITS)'(1 << (WEIGHT_FRAC-1))) >> WEIGHT_FRAC;
   assign asum   = (ACC_BITS+2)'(acc_ff[acc_ax_ff]) +
                   (av[WORD_BITS-1] ? -$signed((ACC_BITS+2)'(wmr))
                                    : $signed((ACC_BITS+2)'(wmr)));
   logic acc_done;
   assign acc_done = cmd.acc_step && acc_ax_ff == 2'd2;

   function automatic logic signed [WORD_BITS-1:0] sat_out(logic signed [ACC_BITS-1:0] v);
      if (v > ACC_BITS'(WMAX)) return WMAX;
      if (v < ACC_BITS'(WMIN)) return WMIN;
      return v[WORD_BITS-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff[0] <= '0; acc_ff[1] <= '0; acc_ff[2] <= '0;
         fault_ff  <= 1'b0;
         acc_ax_ff <= '0;
      end else begin
         if (cmd.acc_step) begin
            acc_ff[acc_ax_ff] <= (asum > (ACC_BITS+2)'(AMAX)) ? AMAX :
                                 (asum < (ACC_BITS+2)'(AMIN)) ? AMIN :
                                 asum[ACC_BITS-1:0];
            acc_ax_ff <= acc_done ? 2'd0 : acc_ax_ff + 2'd1;
         end
         if (cmd.set_fault) fault_ff <= 1'b1;
         if (cmd.emit) begin
            acc_ff[0] <= '0; acc_ff[1] <= '0; acc_ff[2] <= '0;
            fault_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.out_x <= POS_BITS'(sat_out(acc_ff[0]));
         rsp_ff.out_y <= POS_BITS'(sat_out(acc_ff[1]));
         rsp_ff.out_z <= POS_BITS'(sat_out(acc_ff[2]));
         rsp_ff.divide_fault <= fault_ff;
      end
   end

   assign rsp_item = rsp_ff;
   assign status.mat_done = mat_done;
   assign status.div_done = div_done;
   assign status.acc_done = acc_done;
   assign status.w_zero   = (res_ff[3] == '0);
   assign status.bone_ok  = in_range;
   assign status.is_load  = (req_ff.opcode == OP_LOAD);
   assign status.is_last  = req_ff.last_bone;
endmodule

FILE: rtl/core/linear_blend_skinning_vertex.sv
// ----------------------------------------------------------------------------
// linear_blend_skinning_vertex: fixed-point linear blend skinning
// Stores bone pose and inverse bind matrices and blends weighted,
// transformed vertex positions into one skinned position per vertex.
// ----------------------------------------------------------------------------
//   Channel  Direction  Payload         Handshake
//   req      in         req_item_type   req_valid / req_ready
//   rsp      out        rsp_item_type   rsp_valid / rsp_ready
//
// A load item is accepted in idle and its element is written in the wait state,
// so the block takes no new item until the write is done. A contribution is
// decoded in the wait state, then runs two matrix passes on the single shared
// multiplier, one w check, three quotients from the bit-serial divider and an
// accumulate step for each of the three axes. A zero w skips the divider and
// the accumulators. The last item of a vertex adds an emit step, and the next
// item is accepted as soon as the block is back in idle.
// Reset clears the sequencer, the accumulators and the fault flag; the
// matrix stores hold no reset value. A pending response only stalls the emit
// cycle of the next vertex until the response is taken.
module linear_blend_skinning_vertex
   import lbs_pkg::*;
#(
   parameter int MAX_BONES = MAX_BONES_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);
   lbs_cmd_type    cmd;
   lbs_status_type status;

   lbs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .status(status), .cmd(cmd));

   lbs_datapath #(.MAX_BONES(MAX_BONES), .FRAC_BITS(FRAC_BITS))
   u_dp (
      .clock(clock), .reset(reset), .req_item(req_item), .cmd(cmd),
      .status(status), .rsp_item(rsp_item));

   // An offered response stays offered until it is taken.
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");

   // Emit and capture never overlap.
   a_emit_capture: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit && cmd.capture)) else $error("emit and capture together");

   // A held response keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_item)) else $error("response changed");
endmodule
